[design/sfhc_pkg.sv]
package sfhc_pkg;

  // Default frame geometry.
  localparam int DEF_HEADER_BYTES    = 6;
  localparam int DEF_MAC_BYTES       = 16;
  localparam int DEF_MAX_FRAME_BYTES = 1024;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Reset values of the bypass opcode registers.
  localparam logic [31:0] BYPASS_A_RESET = 32'h0100_0000;
  localparam logic [31:0] BYPASS_B_RESET = 32'h2200_B000;
  localparam logic [31:0] BYPASS_C_RESET = 32'h1006_5000;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EXPECTED_SEQ = 3'd0,
    CFG_SEQ_WINDOW   = 3'd1,
    CFG_BYPASS_A     = 3'd2,
    CFG_BYPASS_B     = 3'd3,
    CFG_BYPASS_C     = 3'd4
  } cfg_index_t;

  // Frame status codes.
  typedef enum logic [2:0] {
    ST_MAC_CHECK     = 3'd0,
    ST_BYPASS        = 3'd1,
    ST_SHORT_HEADER  = 3'd2,
    ST_SPI_REJECTED  = 3'd3,
    ST_SEQ_WINDOW    = 3'd4,
    ST_SHORT_OPCODE  = 3'd5,
    ST_SHORT_TRAILER = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_payload_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sequence_number;
    logic [31:0] command_opcode;
  } out_payload_t;

  // Header fields and length flags of one finished frame.
  typedef struct packed {
    logic        short_header;
    logic        short_opcode;
    logic        short_trailer;
    logic        spi_nonzero;
    logic [31:0] sequence_number;
    logic [31:0] command_opcode;
  } frame_snap_t;

endpackage

[design/sfhc_capture.sv]
module sfhc_capture #(
  parameter int HEADER_BYTES    = sfhc_pkg::DEF_HEADER_BYTES,
  parameter int MAC_BYTES       = sfhc_pkg::DEF_MAC_BYTES,
  parameter int MAX_FRAME_BYTES = sfhc_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfhc_pkg::in_payload_t in_payload,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output sfhc_pkg::frame_snap_t snap
);
  import sfhc_pkg::*;

  localparam int          CNT_W    = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [31:0] OP_START = 32'(HEADER_BYTES + 2);
  localparam logic [31:0] OP_END   = 32'(HEADER_BYTES + 6);
  localparam logic [31:0] HDR_LEN  = 32'(HEADER_BYTES);
  localparam logic [31:0] MAC_LEN  = 32'(MAC_BYTES);
  localparam logic [31:0] SPI_END  = 32'd2;
  localparam logic [31:0] SEQ_END  = 32'd6;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      spi_r, spi_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      op_r, op_nxt;
  logic             snap_valid_r, snap_valid_nxt;
  frame_snap_t      snap_r, snap_nxt;
  logic             accept;
  logic [31:0]      cnt_ext;

  assign in_ready   = !snap_valid_r || snap_ready;
  assign accept     = in_valid && in_ready;
  assign cnt_ext    = 32'(cnt_r);
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  // Byte counting, field capture and the end-of-frame snapshot.
  always_comb begin
    logic [CNT_W-1:0] cnt_post;
    logic [15:0]      spi_post;
    logic [31:0]      seq_post;
    logic [31:0]      op_post;
    logic [31:0]      len_post;
    cnt_post       = cnt_r;
    spi_post       = spi_r;
    seq_post       = seq_r;
    op_post        = op_r;
    len_post       = '0;
    cnt_nxt        = cnt_r;
    spi_nxt        = spi_r;
    seq_nxt        = seq_r;
    op_nxt         = op_r;
    snap_nxt       = snap_r;
    snap_valid_nxt = snap_valid_r;
    if (snap_valid_r && snap_ready) begin
      snap_valid_nxt = 1'b0;
    end
    if (accept) begin
      // Bytes beyond the largest frame are ignored.
      if (cnt_r < CNT_W'(MAX_FRAME_BYTES)) begin
        if (cnt_ext < SPI_END) begin
          spi_post = {spi_r[7:0], in_payload.frame_byte};
        end else if (cnt_ext < SEQ_END) begin
          seq_post = {seq_r[23:0], in_payload.frame_byte};
        end
        if (cnt_ext >= OP_START && cnt_ext < OP_END) begin
          op_post = {op_r[23:0], in_payload.frame_byte};
        end
        cnt_post = cnt_r + CNT_W'(1);
      end
      len_post = 32'(cnt_post);
      if (in_payload.end_of_frame) begin
        // Fields whose bytes did not all arrive read as zero.
        snap_nxt.short_header    = len_post < HDR_LEN;
        snap_nxt.short_opcode    = len_post < OP_END;
        snap_nxt.short_trailer   = len_post < MAC_LEN;
        snap_nxt.spi_nonzero     = |spi_post;
        snap_nxt.sequence_number = (len_post < SEQ_END) ? 32'd0 : seq_post;
        snap_nxt.command_opcode  = (len_post < OP_END) ? 32'd0 : op_post;
        snap_valid_nxt           = 1'b1;
        cnt_nxt                  = '0;
        spi_nxt                  = '0;
        seq_nxt                  = '0;
        op_nxt                   = '0;
      end else begin
        cnt_nxt = cnt_post;
        spi_nxt = spi_post;
        seq_nxt = seq_post;
        op_nxt  = op_post;
      end
    end
  end

  // Frame state and snapshot valid are cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      spi_r        <= '0;
      seq_r        <= '0;
      op_r         <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      spi_r        <= spi_nxt;
      seq_r        <= seq_nxt;
      op_r         <= op_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  // Snapshot payload.
  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

endmodule

[design/secure_frame_header_check.sv]
// Security header check for a received frame, fed one byte per transfer.
// The input channel (in_valid/in_ready/in_payload) carries a frame byte and
// an end-of-frame flag. The block captures the security parameter index,
// the sequence number and the command opcode as the bytes go by, and after
// the last byte of each frame it offers exactly one status transfer on the
// output channel (out_valid/out_ready/out_payload).
// Throughput is one byte per cycle while in_ready is high. The status for a
// frame is registered first in the capture stage and then in the status
// register.
// The configuration port (cfg_we/cfg_index/cfg_wdata) writes the expected
// sequence number, the sequence window or one of three bypass opcodes, as
// cfg_index selects; it should be written only while no frame is in flight.
// Indexes beyond the register list are ignored.
// Synchronous reset clears the frame state and both stages and loads the
// register defaults. When the receiver stalls, a finished status waits in
// the output register and a second one in the capture stage; input transfers
// stop while the capture stage holds a status and resume in the cycle in
// which the receiver takes the waiting one.
module secure_frame_header_check #(
  parameter int HEADER_BYTES    = sfhc_pkg::DEF_HEADER_BYTES,
  parameter int MAC_BYTES       = sfhc_pkg::DEF_MAC_BYTES,
  parameter int MAX_FRAME_BYTES = sfhc_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sfhc_pkg::in_payload_t            in_payload,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sfhc_pkg::out_payload_t           out_payload,
  input  logic                             cfg_we,
  input  logic [sfhc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfhc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sfhc_pkg::*;

  logic         exp_ok;
  logic [31:0]  exp_seq_r;
  logic [31:0]  seq_win_r;
  logic [31:0]  bypass_a_r;
  logic [31:0]  bypass_b_r;
  logic [31:0]  bypass_c_r;
  logic         snap_valid;
  logic         snap_ready;
  frame_snap_t  snap;
  logic         out_valid_r, out_valid_nxt;
  out_payload_t out_r, out_nxt;
  logic [31:0]  seq_dist;
  logic         is_bypass;
  status_t      status;

  sfhc_capture #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAC_BYTES       (MAC_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r  <= '0;
      seq_win_r  <= '0;
      bypass_a_r <= BYPASS_A_RESET;
      bypass_b_r <= BYPASS_B_RESET;
      bypass_c_r <= BYPASS_C_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_SEQ: exp_seq_r  <= cfg_wdata;
        CFG_SEQ_WINDOW:   seq_win_r  <= cfg_wdata;
        CFG_BYPASS_A:     bypass_a_r <= cfg_wdata;
        CFG_BYPASS_B:     bypass_b_r <= cfg_wdata;
        CFG_BYPASS_C:     bypass_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequence window and bypass checks.
  assign seq_dist  = snap.sequence_number - exp_seq_r;
  assign exp_ok    = seq_dist <= seq_win_r;
  assign is_bypass = (snap.command_opcode == bypass_a_r) ||
                     (snap.command_opcode == bypass_b_r) ||
                     (snap.command_opcode == bypass_c_r);

  // Status in order of precedence.
  always_comb begin
    if (snap.short_header) begin
      status = ST_SHORT_HEADER;
    end else if (snap.spi_nonzero) begin
      status = ST_SPI_REJECTED;
    end else if (!exp_ok) begin
      status = ST_SEQ_WINDOW;
    end else if (snap.short_opcode) begin
      status = ST_SHORT_OPCODE;
    end else if (is_bypass) begin
      status = ST_BYPASS;
    end else if (snap.short_trailer) begin
      status = ST_SHORT_TRAILER;
    end else begin
      status = ST_MAC_CHECK;
    end
  end

  // Output register: loads whenever it is empty or being emptied.
  assign snap_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (snap_valid && snap_ready) begin
      out_valid_nxt           = 1'b1;
      out_nxt.status          = status;
      out_nxt.sequence_number = snap.sequence_number;
      out_nxt.command_opcode  = snap.command_opcode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

[design/sfhc_checker.sv]
module sfhc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input sfhc_pkg::in_payload_t  in_payload,
  input logic                   out_valid,
  input logic                   out_ready,
  input sfhc_pkg::out_payload_t out_payload
);
  import sfhc_pkg::*;

  logic eof_transfer;

  assign eof_transfer = in_valid && in_ready && in_payload.end_of_frame;

  // A stalled status holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("status changed while stalled");

  // A new status always follows an end-of-frame transfer.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(eof_transfer, 2))
    else $error("status without a preceding end-of-frame byte");

  // The input only stalls when a status is waiting on the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with the output free");

  // A frame too short for its opcode reports no opcode.
  a_short_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_payload.status == ST_SHORT_HEADER ||
                  out_payload.status == ST_SHORT_OPCODE)
    |-> out_payload.command_opcode == 32'd0)
    else $error("opcode reported for a short frame");

endmodule

bind secure_frame_header_check sfhc_checker u_sfhc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);

[sim/secure_frame_header_check_tb.sv]
module secure_frame_header_check_tb;
  import sfhc_pkg::*;

  localparam int HDR_BYTES     = DEF_HEADER_BYTES;
  localparam int TRAILER_BYTES = DEF_MAC_BYTES;
  localparam int MAX_BYTES     = DEF_MAX_FRAME_BYTES;
  localparam int OP_START      = HDR_BYTES + 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 55;
  localparam int REPORT_LIMIT  = 10;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  in_payload_t  in_payload = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  out_payload_t out_payload;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register copies kept alongside the block's own.
  logic [31:0] want_seq;
  logic [31:0] seq_window;
  logic [31:0] bypass_a;
  logic [31:0] bypass_b;
  logic [31:0] bypass_c;

  // Frame being received, as the block should see it.
  int          rx_count;
  logic [15:0] rx_spi;
  logic [31:0] rx_seq;
  logic [31:0] rx_op;

  in_payload_t  byte_q[$];
  out_payload_t verdict_q[$];
  out_payload_t due;

  int  in_gap;
  int  out_stall;
  bit  held;
  bit  in_calm;
  bit  out_calm;
  int  bytes_queued;
  int  bytes_sent;
  int  frames_queued;
  int  statuses_checked;
  int  fail_count;
  int  status_hits[8];

  secure_frame_header_check DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Status of a finished frame of the given saturated length.
  function automatic status_t frame_verdict(input int len);
    logic [31:0] seq_gap;
    seq_gap = rx_seq - want_seq;
    if (len < HDR_BYTES) return ST_SHORT_HEADER;
    if (rx_spi != 16'h0000) return ST_SPI_REJECTED;
    if (seq_gap > seq_window) return ST_SEQ_WINDOW;
    if (len < HDR_BYTES + 6) return ST_SHORT_OPCODE;
    if (rx_op == bypass_a || rx_op == bypass_b || rx_op == bypass_c) return ST_BYPASS;
    if (len < TRAILER_BYTES) return ST_SHORT_TRAILER;
    return ST_MAC_CHECK;
  endfunction

  // Capture one accepted byte; on the last byte of a frame the status is queued.
  task automatic absorb_byte(input in_payload_t p);
    out_payload_t res;
    if (rx_count < MAX_BYTES) begin
      if (rx_count < 2) rx_spi = {rx_spi[7:0], p.frame_byte};
      else if (rx_count < 6) rx_seq = {rx_seq[23:0], p.frame_byte};
      if (rx_count >= OP_START && rx_count < OP_START + 4)
        rx_op = {rx_op[23:0], p.frame_byte};
      rx_count++;
    end
    if (p.end_of_frame) begin
      res.status          = frame_verdict(rx_count);
      res.sequence_number = (rx_count >= 6) ? rx_seq : 32'h0;
      res.command_opcode  = (rx_count >= OP_START + 4) ? rx_op : 32'h0;
      verdict_q.push_back(res);
      rx_count = 0;
      rx_spi   = '0;
      rx_seq   = '0;
      rx_op    = '0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
  endtask

  // Pause before the next transfer: some runs of back-to-back traffic, some gaps.
  function automatic int draw_pause(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Sender: one byte per transfer from the pending queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_byte(in_payload);
        bytes_sent++;
        held = 1'b0;
      end else begin
        held = in_valid;
      end
      if (!held) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_payload <= byte_q.pop_front();
          in_valid   <= 1'b1;
          in_gap = draw_pause(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks each status transfer in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        statuses_checked++;
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected status transfer: status %0d seq %h op %h",
                                  out_payload.status, out_payload.sequence_number,
                                  out_payload.command_opcode));
        end else begin
          due = verdict_q.pop_front();
          status_hits[due.status]++;
          if (out_payload.status !== due.status ||
              out_payload.sequence_number !== due.sequence_number ||
              out_payload.command_opcode !== due.command_opcode)
            flag_mismatch($sformatf({"status mismatch: expected status %0d seq %h op %h,",
                                     " got status %0d seq %h op %h"},
                                    due.status, due.sequence_number, due.command_opcode,
                                    out_payload.status, out_payload.sequence_number,
                                    out_payload.command_opcode));
        end
        out_stall = draw_pause(out_calm);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_EXPECTED_SEQ: want_seq   = val;
      CFG_SEQ_WINDOW:   seq_window = val;
      CFG_BYPASS_A:     bypass_a   = val;
      CFG_BYPASS_B:     bypass_b   = val;
      CFG_BYPASS_C:     bypass_c   = val;
      default: ;
    endcase
  endtask

  // Writes to indexes past the register list must change nothing.
  task automatic poke_unused();
    for (int k = int'(CFG_BYPASS_C) + 1; k < (1 << CFG_INDEX_W); k++)
      cfg_write(CFG_INDEX_W'(k), $urandom);
  endtask

  // Register setting for each random phase, the extremes among them.
  task automatic apply_setting(input int ph);
    case (ph)
      1: begin
        // Window straddling the wrap of the sequence counter.
        cfg_write(CFG_EXPECTED_SEQ, 32'hFFFF_FFF0);
        cfg_write(CFG_SEQ_WINDOW, 32'h0000_001F);
        cfg_write(CFG_BYPASS_A, 32'h0000_0000);
        cfg_write(CFG_BYPASS_B, 32'hFFFF_FFFF);
        cfg_write(CFG_BYPASS_C, $urandom);
        poke_unused();
      end
      2: begin
        cfg_write(CFG_EXPECTED_SEQ, 32'h0000_0000);
        cfg_write(CFG_SEQ_WINDOW, 32'hFFFF_FFFF);
        cfg_write(CFG_BYPASS_A, $urandom);
        cfg_write(CFG_BYPASS_B, $urandom);
        cfg_write(CFG_BYPASS_C, $urandom);
      end
      3: begin
        cfg_write(CFG_EXPECTED_SEQ, $urandom);
        cfg_write(CFG_SEQ_WINDOW, 32'h0000_0000);
        cfg_write(CFG_BYPASS_A, 32'hFFFF_FFFF);
        cfg_write(CFG_BYPASS_B, $urandom);
        cfg_write(CFG_BYPASS_C, 32'h0000_0000);
      end
      4: begin
        // All three bypass opcodes equal.
        cfg_write(CFG_EXPECTED_SEQ, $urandom);
        cfg_write(CFG_SEQ_WINDOW, $urandom_range(0, 1000));
        cfg_write(CFG_BYPASS_A, 32'hA5C3_0F96);
        cfg_write(CFG_BYPASS_B, 32'hA5C3_0F96);
        cfg_write(CFG_BYPASS_C, 32'hA5C3_0F96);
      end
      5: begin
        cfg_write(CFG_EXPECTED_SEQ, 32'hFFFF_FFFF);
        cfg_write(CFG_SEQ_WINDOW, 32'h0000_0001);
        cfg_write(CFG_BYPASS_A, BYPASS_A_RESET);
        cfg_write(CFG_BYPASS_B, BYPASS_B_RESET);
        cfg_write(CFG_BYPASS_C, BYPASS_C_RESET);
      end
      6: begin
        cfg_write(CFG_EXPECTED_SEQ, $urandom);
        cfg_write(CFG_SEQ_WINDOW, $urandom);
        cfg_write(CFG_BYPASS_A, $urandom);
        cfg_write(CFG_BYPASS_B, $urandom);
        cfg_write(CFG_BYPASS_C, $urandom);
        poke_unused();
      end
      default: begin
        cfg_write(CFG_EXPECTED_SEQ, 32'h8000_0000);
        cfg_write(CFG_SEQ_WINDOW, 32'h7FFF_FFFF);
        cfg_write(CFG_BYPASS_A, $urandom);
        cfg_write(CFG_BYPASS_B, 32'h0000_0000);
        cfg_write(CFG_BYPASS_C, 32'hFFFF_FFFF);
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Lay out one frame: SPI and sequence number big-endian in the header,
  // opcode after it, random filler everywhere else.
  task automatic queue_frame(input int len, input logic [15:0] spi,
                             input logic [31:0] seq, input logic [31:0] op);
    in_payload_t item;
    logic [7:0]  b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i < 2) b = spi[15 - 8 * i -: 8];
      else if (i < 6) b = seq[31 - 8 * (i - 2) -: 8];
      else if (i >= OP_START && i < OP_START + 4) b = op[31 - 8 * (i - OP_START) -: 8];
      item.frame_byte   = b;
      item.end_of_frame = (i == len - 1);
      byte_q.push_back(item);
    end
    bytes_queued += len;
    frames_queued++;
  endtask

  // Mostly well-formed frames around the length thresholds, with some noise.
  task automatic queue_random_frame();
    int          len;
    int          pick;
    logic [15:0] spi;
    logic [31:0] seq;
    logic [31:0] op;
    pick = $urandom_range(0, 15);
    if (pick < 2) len = $urandom_range(1, HDR_BYTES - 1);
    else if (pick < 4) len = $urandom_range(HDR_BYTES, HDR_BYTES + 5);
    else if (pick < 6) len = $urandom_range(HDR_BYTES + 6, TRAILER_BYTES - 1);
    else if (pick < 14) len = $urandom_range(TRAILER_BYTES, 32);
    else len = $urandom_range(33, 96);
    spi = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h0000;
    case ($urandom_range(0, 5))
      0: seq = want_seq;
      1: seq = want_seq + seq_window;
      2: seq = want_seq + seq_window + 32'd1;
      3: seq = want_seq + $urandom_range(0, seq_window);
      4: seq = $urandom;
      default: seq = want_seq - 32'd1;
    endcase
    case ($urandom_range(0, 7))
      0: op = bypass_a;
      1: op = bypass_b;
      2: op = bypass_c;
      3: op = 32'h0000_0000;
      4: op = 32'hFFFF_FFFF;
      default: op = $urandom;
    endcase
    queue_frame(len, spi, seq, op);
  endtask

  // Wait until every byte has gone and every status has come back.
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    want_seq   = 32'h0;
    seq_window = 32'h0;
    bypass_a   = BYPASS_A_RESET;
    bypass_b   = BYPASS_B_RESET;
    bypass_c   = BYPASS_C_RESET;
    rx_count   = 0;
    rx_spi     = '0;
    rx_seq     = '0;
    rx_op      = '0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames on the reset register values: each status, the field
    // extremes, and fields cut short by an early end of frame.
    queue_frame(1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_frame(HDR_BYTES - 1, 16'h0000, 32'h0000_0000, 32'h0);
    queue_frame(HDR_BYTES, 16'hFFFF, 32'h0000_0000, 32'h0);
    queue_frame(HDR_BYTES, 16'h0000, 32'h0000_0000, 32'h0);
    queue_frame(OP_START, 16'h0000, 32'h0000_0001, 32'h0);
    queue_frame(HDR_BYTES + 5, 16'h0000, 32'h0000_0000, 32'h0);
    queue_frame(HDR_BYTES + 6, 16'h0000, 32'h0000_0000, BYPASS_A_RESET);
    queue_frame(HDR_BYTES + 6, 16'h0000, 32'h0000_0000, BYPASS_B_RESET);
    queue_frame(HDR_BYTES + 7, 16'h0000, 32'h0000_0000, BYPASS_C_RESET);
    queue_frame(HDR_BYTES + 6, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_frame(TRAILER_BYTES - 1, 16'h0000, 32'h0000_0000, BYPASS_A_RESET + 32'd1);
    queue_frame(TRAILER_BYTES, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    queue_frame(TRAILER_BYTES, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_frame(TRAILER_BYTES, 16'h0001, 32'h0000_0000, BYPASS_B_RESET);
    // One frame running past the size limit; the excess bytes capture nothing.
    queue_frame(MAX_BYTES + $urandom_range(1, 8), 16'h0000, 32'h0000_0000, $urandom);
    wait_idle();

    // Random phases, each under its own register setting and idling mix.
    for (int ph = 1; ph < PHASES; ph++) begin
      apply_setting(ph);
      in_calm  = (ph % 3 == 0);
      out_calm = (ph % 4 == 1);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) queue_random_frame();
      wait_idle();
    end

    $display("Sent %0d bytes in %0d frames over %0d register settings, checked %0d statuses.",
             bytes_sent, frames_queued, PHASES, statuses_checked);
    $display("Statuses seen: mac %0d, bypass %0d, short header %0d, spi %0d, window %0d, %s",
             status_hits[ST_MAC_CHECK], status_hits[ST_BYPASS],
             status_hits[ST_SHORT_HEADER], status_hits[ST_SPI_REJECTED],
             status_hits[ST_SEQ_WINDOW],
             $sformatf("short opcode %0d, short trailer %0d; %0d mismatches.",
                       status_hits[ST_SHORT_OPCODE], status_hits[ST_SHORT_TRAILER],
                       fail_count));
    if (fail_count == 0) begin
      $display("** secure_frame_header_check: PASSED **");
    end else begin
      $display("** secure_frame_header_check: FAILED **");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    #3000000;
    $display("Timed out with %0d bytes pending and %0d statuses outstanding.",
             byte_q.size(), verdict_q.size());
    $display("** secure_frame_header_check: FAILED **");
    $finish;
  end

endmodule

[secure_frame_header_check.f]
design/sfhc_pkg.sv
design/sfhc_capture.sv
design/secure_frame_header_check.sv
design/sfhc_checker.sv
sim/secure_frame_header_check_tb.sv
